// ===== hw/rtl/cpt_pkg.sv =====
// Shared constants and types for the closest-point-on-triangle pipeline.
package cpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int MUL_CHUNK       = 32;
    localparam int MUL_LAT         = 5;

    typedef enum logic [2:0] {
        RGN_A  = 3'd0,
        RGN_B  = 3'd1,
        RGN_AB = 3'd2,
        RGN_C  = 3'd3,
        RGN_AC = 3'd4,
        RGN_BC = 3'd5,
        RGN_IN = 3'd6
    } region_t;

endpackage

// ===== hw/rtl/cpt_mul.sv =====
// Pipelined signed multiplier built from 32x32 partial products.
module cpt_mul import cpt_pkg::*; #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);

    localparam int C  = MUL_CHUNK;
    localparam int NA = (WA + C - 1) / C;
    localparam int NB = (WB + C - 1) / C;
    localparam int PA = NA * C;
    localparam int PB = NB * C;
    localparam int WP = WA + WB;
    localparam int RW = PB + C;
    localparam int SW = PA + PB;

    logic [WA-1:0] a_u, a_mag;
    logic [WB-1:0] b_u, b_mag;

    logic [PA-1:0]     ma_reg;
    logic [PB-1:0]     mb_reg;
    logic [3:0]        neg_reg;
    logic [2*C-1:0]    pp_reg [NA][NB];
    logic [RW-1:0]     row_reg [NA];
    logic [RW-1:0]     row_next [NA];
    logic [WP-1:0]     mag_reg;
    logic [SW-1:0]     acc_next;
    logic signed [WP-1:0] p_reg;

    assign a_u   = a;
    assign b_u   = b;
    assign a_mag = a[WA-1] ? (~a_u + 1'b1) : a_u;
    assign b_mag = b[WB-1] ? (~b_u + 1'b1) : b_u;

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++) begin
                row_next[i] = row_next[i] + (RW'(pp_reg[i][j]) << (j * C));
            end
        end
    end

    always_comb begin
        acc_next = '0;
        for (int i = 0; i < NA; i++) begin
            acc_next = acc_next + (SW'(row_reg[i]) << (i * C));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg     <= PA'(a_mag);
            mb_reg     <= PB'(b_mag);
            neg_reg[0] <= a[WA-1] ^ b[WB-1];
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    pp_reg[i][j] <= ma_reg[i*C +: C] * mb_reg[j*C +: C];
                end
                row_reg[i] <= row_next[i];
            end
            neg_reg[3:1] <= neg_reg[2:0];
            mag_reg      <= acc_next[WP-1:0];
            p_reg        <= neg_reg[3] ? -$signed(mag_reg) : $signed(mag_reg);
        end
    end

    assign p = p_reg;

endmodule

// ===== hw/rtl/cpt_dly.sv =====
// Enabled delay line for side data that travels with the pipeline.
module cpt_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] d_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++) begin
                d_reg[k] <= d_reg[k-1];
            end
        end
    end

    assign dout = d_reg[DEPTH-1];

endmodule

// ===== hw/rtl/cpt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded ratio.
module cpt_div #(
    parameter int NW = 171,
    parameter int DW = 139,
    parameter int QB = 33
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic [QB-1:0]        q,
    output logic                 big,
    output logic                 neg
);

    localparam int MW   = (NW > DW) ? NW : DW;
    localparam int RW   = MW + 2;
    localparam int VW   = DW + 1;
    localparam int CMPW = (RW > VW + QB) ? RW : VW + QB;

    logic [NW-1:0]   num_u, na;
    logic [DW-1:0]   den_u, da;
    logic [RW-1:0]   n2;
    logic [VW-1:0]   d2;
    logic            big_next;

    logic [RW-1:0]   rem_reg [QB+1];
    logic [VW-1:0]   dv_reg  [QB+1];
    logic [QB-1:0]   q_reg   [QB+1];
    logic            big_reg [QB+1];
    logic            neg_reg [QB+1];

    assign num_u    = num;
    assign den_u    = den;
    assign na       = num[NW-1] ? (~num_u + 1'b1) : num_u;
    assign da       = den[DW-1] ? (~den_u + 1'b1) : den_u;
    assign n2       = (RW'(na) << 1) + RW'(da);
    assign d2       = {da, 1'b0};
    assign big_next = CMPW'(n2) >= (CMPW'(d2) << QB);

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= n2;
            dv_reg[0]  <= d2;
            q_reg[0]   <= '0;
            big_reg[0] <= big_next;
            neg_reg[0] <= num[NW-1] ^ den[DW-1];
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_step
        localparam int K = QB - 1 - s;
        logic [CMPW-1:0] sub;
        logic [CMPW-1:0] rem_w;

        assign sub   = CMPW'(dv_reg[s]) << K;
        assign rem_w = CMPW'(rem_reg[s]);

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_w >= sub) begin
                    rem_reg[s+1] <= RW'(rem_w - sub);
                    q_reg[s+1]   <= q_reg[s] | (QB'(1) << K);
                end else begin
                    rem_reg[s+1] <= rem_reg[s];
                    q_reg[s+1]   <= q_reg[s];
                end
                dv_reg[s+1]  <= dv_reg[s];
                big_reg[s+1] <= big_reg[s];
                neg_reg[s+1] <= neg_reg[s];
            end
        end
    end

    assign q   = q_reg[QB];
    assign big = big_reg[QB];
    assign neg = neg_reg[QB];

endmodule

// ===== hw/rtl/closest_point_on_triangle.sv =====
// Throughput: one item per cycle unless the output stalls; the divider retires one quotient bit per stage.
// The whole pipeline holds while a result waits at the output.
// Reset clears the valid bits only; datapath registers are not reset.
module closest_point_on_triangle import cpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_px,
    input  logic signed [COORD_WIDTH-1:0] s_py,
    input  logic signed [COORD_WIDTH-1:0] s_pz,
    input  logic signed [COORD_WIDTH-1:0] s_ax,
    input  logic signed [COORD_WIDTH-1:0] s_ay,
    input  logic signed [COORD_WIDTH-1:0] s_az,
    input  logic signed [COORD_WIDTH-1:0] s_bx,
    input  logic signed [COORD_WIDTH-1:0] s_by_coord,
    input  logic signed [COORD_WIDTH-1:0] s_bz,
    input  logic signed [COORD_WIDTH-1:0] s_cx,
    input  logic signed [COORD_WIDTH-1:0] s_cy,
    input  logic signed [COORD_WIDTH-1:0] s_cz,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_WIDTH-1:0] m_qx,
    output logic signed [COORD_WIDTH-1:0] m_qy,
    output logic signed [COORD_WIDTH-1:0] m_qz,
    output logic [2:0]                    m_region,
    output logic                          m_degenerate
);

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int VPW  = 2 * DOTW;
    localparam int VW   = VPW + 1;
    localparam int EW   = DOTW + 1;
    localparam int YW   = VW;
    localparam int NPW  = DW + YW;
    localparam int NUMW = NPW + 1;
    localparam int DENW = VW + 2;
    localparam int QB   = CW + 1;
    localparam int SW   = QB + 3;
    localparam int LAT  = 3 * (MUL_LAT + 1) + QB + 4;
    localparam int GW   = 9 * CW + 9 * DW;
    localparam int S1W  = 4 + DENW + 6 * CW;
    localparam int S2W  = 5 + 6 * CW;
    localparam int VA_IDX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int VB_IDX [6] = '{3, 1, 1, 5, 5, 3};

    logic             en;
    logic [LAT-1:0]   vld_reg;

    // input stage
    logic signed [CW-1:0] pin [3];
    logic signed [CW-1:0] ain [3];
    logic signed [CW-1:0] bin [3];
    logic signed [CW-1:0] cin [3];
    logic signed [CW-1:0] a_s1_reg [3];
    logic signed [CW-1:0] b_s1_reg [3];
    logic signed [CW-1:0] c_s1_reg [3];
    logic signed [DW-1:0] u_s1_reg [2][3];
    logic signed [DW-1:0] w_s1_reg [3][3];
    logic signed [DW-1:0] bc_s1_reg [3];

    // dot products and region terms
    logic signed [PW-1:0]   dp [6][3];
    logic signed [DOTW-1:0] d_reg [6];
    logic signed [VPW-1:0]  vp [6];
    logic signed [VW-1:0]   vc_reg, vb_reg, va_reg;

    // delayed operands
    logic [GW-1:0]          g_in, g_out;
    logic [6*DOTW-1:0]      dd_in, dd_out;
    logic signed [DOTW-1:0] dd [6];
    logic signed [CW-1:0]   ga [3];
    logic signed [CW-1:0]   gb [3];
    logic signed [CW-1:0]   gc [3];
    logic signed [DW-1:0]   gab [3];
    logic signed [DW-1:0]   gac [3];
    logic signed [DW-1:0]   gbc [3];

    // region decision
    logic signed [EW-1:0]   e1, e2;
    logic [5:0]             dpos, dneg;
    logic                   vc_pos, vb_pos, va_pos;
    region_t                region_next;
    logic                   isdiv_next;
    logic signed [DW-1:0]   x1_next [3];
    logic signed [YW-1:0]   y1_next, y2_next;
    logic signed [DENW-1:0] den_next;
    logic signed [CW-1:0]   base_next [3];

    region_t                region_reg;
    logic                   isdiv_reg;
    logic signed [DW-1:0]   x1_reg [3];
    logic signed [DW-1:0]   x2_reg [3];
    logic signed [YW-1:0]   y1_reg, y2_reg;
    logic signed [DENW-1:0] den_reg;
    logic signed [CW-1:0]   base_reg [3];
    logic signed [CW-1:0]   a_reg [3];

    // numerators and division
    logic signed [NPW-1:0]  np1 [3];
    logic signed [NPW-1:0]  np2 [3];
    logic signed [NUMW-1:0] num_reg [3];
    logic [S1W-1:0]         s1_in, s1_out;
    region_t                region1;
    logic                   isdiv1, den_zero1;
    logic signed [DENW-1:0] den1;
    logic signed [CW-1:0]   base1 [3];
    logic signed [CW-1:0]   a1 [3];
    logic [S2W-1:0]         s2_in, s2_out;
    region_t                region2;
    logic                   isdiv2, den_zero2;
    logic signed [CW-1:0]   base2 [3];
    logic signed [CW-1:0]   a2 [3];
    logic [QB-1:0]          dq [3];
    logic                   dbig [3];
    logic                   dneg_q [3];

    // output stage
    logic signed [SW-1:0]   hi_c, lo_c;
    logic signed [CW-1:0]   q_next [3];
    logic signed [CW-1:0]   q_reg [3];
    region_t                region_o_reg;
    logic                   degen_reg;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_valid};
        end
    end

    assign pin = '{s_px, s_py, s_pz};
    assign ain = '{s_ax, s_ay, s_az};
    assign bin = '{s_bx, s_by_coord, s_bz};
    assign cin = '{s_cx, s_cy, s_cz};

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                a_s1_reg[i]    <= ain[i];
                b_s1_reg[i]    <= bin[i];
                c_s1_reg[i]    <= cin[i];
                u_s1_reg[0][i] <= DW'(bin[i]) - DW'(ain[i]);
                u_s1_reg[1][i] <= DW'(cin[i]) - DW'(ain[i]);
                bc_s1_reg[i]   <= DW'(cin[i]) - DW'(bin[i]);
                w_s1_reg[0][i] <= DW'(pin[i]) - DW'(ain[i]);
                w_s1_reg[1][i] <= DW'(pin[i]) - DW'(bin[i]);
                w_s1_reg[2][i] <= DW'(pin[i]) - DW'(cin[i]);
            end
        end
    end

    for (genvar gk = 0; gk < 6; gk++) begin : g_dot
        for (genvar gi = 0; gi < 3; gi++) begin : g_coord
            cpt_mul #(.WA(DW), .WB(DW)) u_dmul (
                .aclk (aclk),
                .en   (en),
                .a    (u_s1_reg[gk % 2][gi]),
                .b    (w_s1_reg[gk / 2][gi]),
                .p    (dp[gk][gi])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 6; k++) begin
                d_reg[k] <= DOTW'(dp[k][0]) + DOTW'(dp[k][1]) + DOTW'(dp[k][2]);
            end
        end
    end

    for (genvar gv = 0; gv < 6; gv++) begin : g_vmul
        cpt_mul #(.WA(DOTW), .WB(DOTW)) u_vmul (
            .aclk (aclk),
            .en   (en),
            .a    (d_reg[VA_IDX[gv]]),
            .b    (d_reg[VB_IDX[gv]]),
            .p    (vp[gv])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vc_reg <= VW'(vp[0]) - VW'(vp[1]);
            vb_reg <= VW'(vp[2]) - VW'(vp[3]);
            va_reg <= VW'(vp[4]) - VW'(vp[5]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g_in[i*CW +: CW]              = a_s1_reg[i];
            g_in[(3+i)*CW +: CW]          = b_s1_reg[i];
            g_in[(6+i)*CW +: CW]          = c_s1_reg[i];
            g_in[9*CW + i*DW +: DW]       = u_s1_reg[0][i];
            g_in[9*CW + (3+i)*DW +: DW]   = u_s1_reg[1][i];
            g_in[9*CW + (6+i)*DW +: DW]   = bc_s1_reg[i];
        end
        for (int i = 0; i < 3; i++) begin
            ga[i]  = g_out[i*CW +: CW];
            gb[i]  = g_out[(3+i)*CW +: CW];
            gc[i]  = g_out[(6+i)*CW +: CW];
            gab[i] = g_out[9*CW + i*DW +: DW];
            gac[i] = g_out[9*CW + (3+i)*DW +: DW];
            gbc[i] = g_out[9*CW + (6+i)*DW +: DW];
        end
        for (int k = 0; k < 6; k++) begin
            dd_in[k*DOTW +: DOTW] = d_reg[k];
            dd[k]                 = dd_out[k*DOTW +: DOTW];
        end
    end

    cpt_dly #(.W(GW), .DEPTH(2 * (MUL_LAT + 1))) u_geom_dly (
        .aclk (aclk),
        .en   (en),
        .din  (g_in),
        .dout (g_out)
    );

    cpt_dly #(.W(6 * DOTW), .DEPTH(MUL_LAT + 1)) u_dot_dly (
        .aclk (aclk),
        .en   (en),
        .din  (dd_in),
        .dout (dd_out)
    );

    always_comb begin
        e1 = EW'(dd[3]) - EW'(dd[2]);
        e2 = EW'(dd[4]) - EW'(dd[5]);
        for (int k = 0; k < 6; k++) begin
            dneg[k] = dd[k][DOTW-1];
            dpos[k] = !dd[k][DOTW-1] && (dd[k] != '0);
        end
        vc_pos = !vc_reg[VW-1] && (vc_reg != '0);
        vb_pos = !vb_reg[VW-1] && (vb_reg != '0);
        va_pos = !va_reg[VW-1] && (va_reg != '0);

        region_next = RGN_IN;
        isdiv_next  = 1'b1;
        x1_next     = gab;
        y1_next     = vb_reg;
        y2_next     = vc_reg;
        den_next    = DENW'(va_reg) + DENW'(vb_reg) + DENW'(vc_reg);
        base_next   = ga;

        priority if (!dpos[0] && !dpos[1]) begin
            region_next = RGN_A;
            isdiv_next  = 1'b0;
        end else if (!dneg[2] && (dd[3] <= dd[2])) begin
            region_next = RGN_B;
            isdiv_next  = 1'b0;
            base_next   = gb;
        end else if (!vc_pos && !dneg[0] && !dpos[2]) begin
            region_next = RGN_AB;
            y1_next     = YW'(dd[0]);
            y2_next     = '0;
            den_next    = DENW'(dd[0]) - DENW'(dd[2]);
        end else if (!dneg[5] && (dd[4] <= dd[5])) begin
            region_next = RGN_C;
            isdiv_next  = 1'b0;
            base_next   = gc;
        end else if (!vb_pos && !dneg[1] && !dpos[5]) begin
            region_next = RGN_AC;
            x1_next     = gac;
            y1_next     = YW'(dd[1]);
            y2_next     = '0;
            den_next    = DENW'(dd[1]) - DENW'(dd[5]);
        end else if (!va_pos && !e1[EW-1] && !e2[EW-1]) begin
            region_next = RGN_BC;
            x1_next     = gbc;
            y1_next     = YW'(e1);
            y2_next     = '0;
            den_next    = DENW'(e1) + DENW'(e2);
            base_next   = gb;
        end else begin
            region_next = RGN_IN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            region_reg <= region_next;
            isdiv_reg  <= isdiv_next;
            x1_reg     <= x1_next;
            x2_reg     <= gac;
            y1_reg     <= y1_next;
            y2_reg     <= y2_next;
            den_reg    <= den_next;
            base_reg   <= base_next;
            a_reg      <= ga;
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_num
        cpt_mul #(.WA(DW), .WB(YW)) u_nmul1 (
            .aclk (aclk),
            .en   (en),
            .a    (x1_reg[gi]),
            .b    (y1_reg),
            .p    (np1[gi])
        );
        cpt_mul #(.WA(DW), .WB(YW)) u_nmul2 (
            .aclk (aclk),
            .en   (en),
            .a    (x2_reg[gi]),
            .b    (y2_reg),
            .p    (np2[gi])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                num_reg[i] <= NUMW'(np1[i]) + NUMW'(np2[i]);
            end
        end
    end

    always_comb begin
        s1_in[2:0]        = region_reg;
        s1_in[3]          = isdiv_reg;
        s1_in[4 +: DENW]  = den_reg;
        for (int i = 0; i < 3; i++) begin
            s1_in[4 + DENW + i*CW +: CW]     = base_reg[i];
            s1_in[4 + DENW + (3+i)*CW +: CW] = a_reg[i];
        end
        region1   = region_t'(s1_out[2:0]);
        isdiv1    = s1_out[3];
        den1      = s1_out[4 +: DENW];
        den_zero1 = (den1 == '0);
        for (int i = 0; i < 3; i++) begin
            base1[i] = s1_out[4 + DENW + i*CW +: CW];
            a1[i]    = s1_out[4 + DENW + (3+i)*CW +: CW];
        end
        s2_in[2:0] = region1;
        s2_in[3]   = isdiv1;
        s2_in[4]   = den_zero1;
        for (int i = 0; i < 3; i++) begin
            s2_in[5 + i*CW +: CW]     = base1[i];
            s2_in[5 + (3+i)*CW +: CW] = a1[i];
        end
        region2   = region_t'(s2_out[2:0]);
        isdiv2    = s2_out[3];
        den_zero2 = s2_out[4];
        for (int i = 0; i < 3; i++) begin
            base2[i] = s2_out[5 + i*CW +: CW];
            a2[i]    = s2_out[5 + (3+i)*CW +: CW];
        end
    end

    cpt_dly #(.W(S1W), .DEPTH(MUL_LAT + 1)) u_side1_dly (
        .aclk (aclk),
        .en   (en),
        .din  (s1_in),
        .dout (s1_out)
    );

    cpt_dly #(.W(S2W), .DEPTH(QB + 1)) u_side2_dly (
        .aclk (aclk),
        .en   (en),
        .din  (s2_in),
        .dout (s2_out)
    );

    for (genvar gi = 0; gi < 3; gi++) begin : g_div
        cpt_div #(.NW(NUMW), .DW(DENW), .QB(QB)) u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num_reg[gi]),
            .den  (den1),
            .q    (dq[gi]),
            .big  (dbig[gi]),
            .neg  (dneg_q[gi])
        );
    end

    assign hi_c = SW'($signed({1'b0, {(CW-1){1'b1}}}));
    assign lo_c = SW'($signed({1'b1, {(CW-1){1'b0}}}));

    always_comb begin
        logic [QB:0]          mag;
        logic signed [SW-1:0] mag_s;
        logic signed [SW-1:0] sum;
        for (int i = 0; i < 3; i++) begin
            mag   = dbig[i] ? ((QB+1)'(1) << QB) : {1'b0, dq[i]};
            mag_s = SW'($signed({1'b0, mag}));
            sum   = dneg_q[i] ? (SW'(base2[i]) - mag_s) : (SW'(base2[i]) + mag_s);
            priority if (!isdiv2) begin
                q_next[i] = base2[i];
            end else if (den_zero2) begin
                q_next[i] = a2[i];
            end else if (sum > hi_c) begin
                q_next[i] = hi_c[CW-1:0];
            end else if (sum < lo_c) begin
                q_next[i] = lo_c[CW-1:0];
            end else begin
                q_next[i] = sum[CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg        <= q_next;
            region_o_reg <= region2;
            degen_reg    <= isdiv2 && den_zero2;
        end
    end

    assign m_qx         = q_reg[0];
    assign m_qy         = q_reg[1];
    assign m_qz         = q_reg[2];
    assign m_region     = region_o_reg;
    assign m_degenerate = degen_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |->
        (m_region == RGN_AB || m_region == RGN_AC || m_region == RGN_BC || m_region == RGN_IN))
        else $error("degenerate flag on a vertex region");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_region == RGN_A || m_region == RGN_B || m_region == RGN_C)) |->
        !m_degenerate)
        else $error("vertex region carries a divide result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

endmodule

// ===== test/closest_point_checker.sv =====
// Checker for closest_point_on_triangle: predicts each result and compares it.
module closest_point_checker import cpt_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_px,
    input  logic signed [31:0] s_py,
    input  logic signed [31:0] s_pz,
    input  logic signed [31:0] s_ax,
    input  logic signed [31:0] s_ay,
    input  logic signed [31:0] s_az,
    input  logic signed [31:0] s_bx,
    input  logic signed [31:0] s_by_coord,
    input  logic signed [31:0] s_bz,
    input  logic signed [31:0] s_cx,
    input  logic signed [31:0] s_cy,
    input  logic signed [31:0] s_cz,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_qx,
    input  logic signed [31:0] m_qy,
    input  logic signed [31:0] m_qz,
    input  logic [2:0]         m_region,
    input  logic               m_degenerate,
    output int                 errors,
    output int                 pending
);

    typedef logic signed [255:0] wide_t;

    localparam wide_t COORD_MAX = (256'sd1 <<< 31) - 256'sd1;
    localparam wide_t COORD_MIN = -(256'sd1 <<< 31);

    typedef struct {
        logic signed [31:0] q[3];
        region_t            rgn;
        logic               degen;
    } closest_t;

    closest_t expected_points[$];

    function automatic logic signed [31:0] round_along(wide_t base, wide_t numer, wide_t den);
        logic [255:0] na, da, quo;
        wide_t m, r;
        logic neg;
        neg = (numer < 0) != (den < 0);
        na = (numer < 0) ? -numer : numer;
        da = (den < 0) ? -den : den;
        quo = (na + na + da) / (da + da);
        m = (quo >= (256'd1 << 62)) ? (256'sd1 <<< 62) : $signed(quo);
        r = neg ? base - m : base + m;
        if (r > COORD_MAX) r = COORD_MAX;
        if (r < COORD_MIN) r = COORD_MIN;
        return r[31:0];
    endfunction

    function automatic wide_t dot(wide_t u[3], wide_t v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic closest_t predict_closest(logic signed [31:0] f[12]);
        wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den;
        closest_t res;
        for (int i = 0; i < 3; i++) begin
            p[i] = f[i];
            a[i] = f[3 + i];
            b[i] = f[6 + i];
            c[i] = f[9 + i];
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
            res.q[i] = f[3 + i];
        end
        res.degen = 1'b0;
        d1 = dot(ab, ap);
        d2 = dot(ac, ap);
        d3 = dot(ab, bp);
        d4 = dot(ac, bp);
        d5 = dot(ab, cp);
        d6 = dot(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        e1 = d4 - d3;
        e2 = d5 - d6;
        if (d1 <= 0 && d2 <= 0) begin
            res.rgn = RGN_A;
        end else if (d3 >= 0 && d4 <= d3) begin
            res.rgn = RGN_B;
            for (int i = 0; i < 3; i++) res.q[i] = f[6 + i];
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            res.rgn = RGN_AB;
            den = d1 - d3;
            if (den == 0) res.degen = 1'b1;
            else for (int i = 0; i < 3; i++) res.q[i] = round_along(a[i], ab[i] * d1, den);
        end else if (d6 >= 0 && d5 <= d6) begin
            res.rgn = RGN_C;
            for (int i = 0; i < 3; i++) res.q[i] = f[9 + i];
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            res.rgn = RGN_AC;
            den = d2 - d6;
            if (den == 0) res.degen = 1'b1;
            else for (int i = 0; i < 3; i++) res.q[i] = round_along(a[i], ac[i] * d2, den);
        end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
            res.rgn = RGN_BC;
            den = e1 + e2;
            if (den == 0) res.degen = 1'b1;
            else for (int i = 0; i < 3; i++) res.q[i] = round_along(b[i], bc[i] * e1, den);
        end else begin
            res.rgn = RGN_IN;
            den = va + vb + vc;
            if (den == 0) res.degen = 1'b1;
            else for (int i = 0; i < 3; i++)
                res.q[i] = round_along(a[i], ab[i] * vb + ac[i] * vc, den);
        end
        return res;
    endfunction

    initial errors = 0;
    initial pending = 0;

    always @(posedge aclk) begin
        logic signed [31:0] f[12];
        closest_t want;
        if (aresetn && s_valid && s_ready) begin
            f = '{s_px, s_py, s_pz, s_ax, s_ay, s_az, s_bx, s_by_coord, s_bz, s_cx, s_cy, s_cz};
            expected_points.push_back(predict_closest(f));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected item: q=(%0d,%0d,%0d) region=%0d",
                    m_qx, m_qy, m_qz, m_region);
            end else begin
                want = expected_points.pop_front();
                if (m_qx !== want.q[0] || m_qy !== want.q[1] || m_qz !== want.q[2] ||
                    m_region !== want.rgn || m_degenerate !== want.degen) begin
                    errors++;
                    if (errors <= 10) $display(
                        "mismatch: exp q=(%0d,%0d,%0d) rgn=%0d dg=%0b got (%0d,%0d,%0d) %0d %0b",
                        want.q[0], want.q[1], want.q[2], want.rgn, want.degen,
                        m_qx, m_qy, m_qz, m_region, m_degenerate);
                end
            end
        end
        pending = expected_points.size();
    end

endmodule

// ===== test/closest_point_on_triangle_test.sv =====
// Testbench top for closest_point_on_triangle: stimulus, idling and verdict.
module closest_point_on_triangle_test;

    localparam int ONE = 65536;
    localparam int WATCHDOG_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] fld[12];
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_qx, m_qy, m_qz;
    logic [2:0] m_region;
    logic m_degenerate;
    int errors, pending;
    int idle_cycles = 0;
    bit allow_stalls = 1'b1;

    initial foreach (fld[i]) fld[i] = '0;

    always #6 aclk = ~aclk;

    closest_point_on_triangle dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_px(fld[0]), .s_py(fld[1]), .s_pz(fld[2]),
        .s_ax(fld[3]), .s_ay(fld[4]), .s_az(fld[5]),
        .s_bx(fld[6]), .s_by_coord(fld[7]), .s_bz(fld[8]),
        .s_cx(fld[9]), .s_cy(fld[10]), .s_cz(fld[11]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_qx(m_qx), .m_qy(m_qy), .m_qz(m_qz),
        .m_region(m_region), .m_degenerate(m_degenerate)
    );

    closest_point_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_px(fld[0]), .s_py(fld[1]), .s_pz(fld[2]),
        .s_ax(fld[3]), .s_ay(fld[4]), .s_az(fld[5]),
        .s_bx(fld[6]), .s_by_coord(fld[7]), .s_bz(fld[8]),
        .s_cx(fld[9]), .s_cy(fld[10]), .s_cz(fld[11]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_qx(m_qx), .m_qy(m_qy), .m_qz(m_qz),
        .m_region(m_region), .m_degenerate(m_degenerate),
        .errors(errors), .pending(pending)
    );

    // hold off the result side in short random bursts
    always @(negedge aclk) begin
        int stall_left;
        if (stall_left > 0) begin
            stall_left--;
            m_ready = 1'b0;
        end else if (allow_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("closest_point_on_triangle_test: errors");
            $finish;
        end
    end

    task automatic send_point(logic signed [31:0] v[12]);
        if (allow_stalls && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        fld = v;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] rand_coord(int kind);
        case (kind)
            0: return $signed($urandom_range(0, 8 * ONE)) - 4 * ONE;
            1: return $signed($urandom() >> 8) - $signed(32'h0080_0000);
            2: return $urandom();
            default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
        endcase
    endfunction

    task automatic send_shape(int px, int py, int pz);
        logic signed [31:0] v[12];
        v = '{px, py, pz, 0, 0, 0, 4 * ONE, 0, 0, 0, 4 * ONE, 0};
        send_point(v);
    endtask

    initial begin
        logic signed [31:0] v[12];
        int kind;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // every region of a right triangle in the z = 0 plane
        send_shape(-ONE, -ONE, ONE);
        send_shape(6 * ONE, -ONE, 0);
        send_shape(2 * ONE, -ONE, 3 * ONE);
        send_shape(-ONE, 6 * ONE, 0);
        send_shape(-ONE, 2 * ONE, -ONE);
        send_shape(3 * ONE, 3 * ONE, ONE);
        send_shape(ONE, ONE, 5 * ONE);
        send_shape(ONE + 1, 3, -7);
        // all zeros, coincident vertices, collinear vertices
        v = '{default: 0};
        send_point(v);
        v = '{ONE, 2 * ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_point(v);
        v = '{ONE, 5 * ONE, 0, 0, 0, 0, 4 * ONE, 0, 0, 4 * ONE, 0, 0};
        send_point(v);
        v = '{ONE, 5 * ONE, 0, 0, 0, 0, 2 * ONE, 0, 0, 4 * ONE, 0, 0};
        send_point(v);
        v = '{2 * ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 4 * ONE, 0, 0};
        send_point(v);
        // range extremes
        v = '{default: 32'sh7fff_ffff};
        send_point(v);
        v = '{default: 32'sh8000_0000};
        send_point(v);
        v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh7fff_ffff};
        send_point(v);
        v = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0,
              32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh7fff_ffff, 32'sh8000_0000};
        send_point(v);

        for (int n = 0; n < 1000; n++) begin
            if (n == 400) begin
                s_valid = 1'b0;
                wait (pending == 0);
                @(negedge aclk);
            end
            if (n == 850) allow_stalls = 1'b0;
            kind = $urandom_range(0, 9);
            kind = (kind < 5) ? 0 : (kind < 7) ? 1 : (kind < 9) ? 2 : 3;
            foreach (v[i]) v[i] = rand_coord(kind);
            case ($urandom_range(0, 9))
                0: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
                1: for (int i = 0; i < 3; i++) v[9 + i] = v[6 + i];
                2: for (int i = 0; i < 3; i++) begin
                    v[6 + i] = v[3 + i];
                    v[9 + i] = v[3 + i];
                end
                3: for (int i = 0; i < 3; i++) v[9 + i] = v[6 + i] + v[6 + i] - v[3 + i];
                default: ;
            endcase
            send_point(v);
        end
        s_valid = 1'b0;

        wait (pending == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0) $display("closest_point_on_triangle_test: clean");
        else $display("closest_point_on_triangle_test: errors");
        $finish;
    end

endmodule
